@@ hw/rtl/btbp_pkg.sv @@
package btbp_pkg;

    localparam int PRICE_W = 48;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_AW  = 2;
    localparam int STEP_W  = 11;

    localparam logic [VAL_W-1:0]   ONE_Q31   = 32'h8000_0000;
    localparam logic [PRICE_W-1:0] PRICE_MAX = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_STEP_COUNT    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_UP_DOWN_RATIO = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_UP_PROB       = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_DISCOUNT      = 2'd3;

    // one lattice update request: v[i] and v[i+1] of the previous row
    typedef struct packed {
        logic             vld;
        logic [VAL_W-1:0] v_lo;
        logic [VAL_W-1:0] v_hi;
    } t_ind_req;

    // clamped coefficients, held for the whole item
    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] q;
        logic [VAL_W-1:0] disc;
    } t_coef;

endpackage

@@ hw/rtl/binomial_tree_binary_put_core.sv @@
// Cash-or-nothing put priced on a recombining binomial lattice.
// Configuration: write i_cfg_we with i_cfg_addr (0 step count, 1 up/down ratio,
// 2 up probability, 3 discount) and i_cfg_wdata, only while busy is low.
// Request: present i_lowest_price and i_strike with start; the request is taken
// at an edge where start is high and busy is low. busy stays high until the
// result is formed.
// Result: o_option_value is shown for a single cycle with o_done; it cannot be
// held off and must be taken in that cycle. busy is already low during that
// cycle, so the next request may be issued alongside it.
// The step count n is clamped to 1..MAX_STEPS. The lattice sits in one RAM
// with one write and one registered read port; each row of the induction
// streams one node a cycle through a three-stage multiply pipeline, which
// drains before the next row starts. Terminal prices are formed one node at
// a time on one shared 24x32 multiplier.
// Reset restores the register defaults and returns the sequencer to idle; the
// RAM needs no clearing since every entry is written before it is read.
module binomial_tree_binary_put_core #(
    parameter int MAX_STEPS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btbp_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [btbp_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic [btbp_pkg::PRICE_W-1:0]      i_lowest_price,
    input  logic [btbp_pkg::PRICE_W-1:0]      i_strike,
    output logic                              o_done,
    output logic [btbp_pkg::VAL_W-1:0]        o_option_value
);
    import btbp_pkg::*;

    localparam int AW = $clog2(MAX_STEPS + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_TERM_WR   = 3'd1;
    localparam logic [2:0] S_TERM_MUL  = 3'd2;
    localparam logic [2:0] S_IND_RD    = 3'd3;
    localparam logic [2:0] S_IND_DRAIN = 3'd4;
    localparam logic [2:0] S_FETCH     = 3'd5;
    localparam logic [2:0] S_LOAD      = 3'd6;

    // configuration
    logic [STEP_W-1:0] r_step_count;
    logic [31:0]       r_ratio;
    logic [31:0]       r_up_prob;
    logic [31:0]       r_discount;

    logic [2:0]         r_state;
    logic [PRICE_W-1:0] r_price;
    logic [PRICE_W-1:0] r_strike;
    logic [AW-1:0]      r_n;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_m;
    logic [AW-1:0]      r_rd_addr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_tag;
    logic [VAL_W-1:0]   r_prev;
    t_coef              r_coef;
    logic [VAL_W-1:0]   r_result;
    logic               r_done;

    logic [31:0]        w_sc32;
    logic [AW-1:0]      w_n;
    logic [VAL_W-1:0]   w_p;
    logic [VAL_W-1:0]   w_disc;
    logic [AW-1:0]      w_last;

    logic               w_price_start;
    logic               w_price_done;
    logic [PRICE_W-1:0] w_price_res;

    t_ind_req           w_req;
    logic [AW-1:0]      w_req_addr;
    logic               w_ind_wr_vld;
    logic [AW-1:0]      w_ind_wr_addr;
    logic [VAL_W-1:0]   w_ind_wr_data;
    logic               w_ind_busy;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [VAL_W-1:0]   w_rdata;

    // step count clamped to 1..MAX_STEPS, coefficients clamped to 1.0
    always_comb begin
        w_sc32 = 32'(r_step_count);
        if (w_sc32 == 32'd0) begin
            w_n = AW'(1);
        end else if (w_sc32 > 32'(MAX_STEPS)) begin
            w_n = AW'(MAX_STEPS);
        end else begin
            w_n = AW'(w_sc32);
        end
    end

    assign w_p    = (r_up_prob > ONE_Q31) ? ONE_Q31 : r_up_prob;
    assign w_disc = (r_discount > ONE_Q31) ? ONE_Q31 : r_discount;
    assign w_last = r_m + AW'(1);

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= STEP_W'(1);
            r_ratio      <= 32'h4000_0000;
            r_up_prob    <= 32'h4000_0000;
            r_discount   <= 32'h8000_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_STEP_COUNT:    r_step_count <= i_cfg_wdata[STEP_W-1:0];
                CFG_UP_DOWN_RATIO: r_ratio      <= i_cfg_wdata;
                CFG_UP_PROB:       r_up_prob    <= i_cfg_wdata;
                CFG_DISCOUNT:      r_discount   <= i_cfg_wdata;
                default:           r_ratio      <= r_ratio;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= (r_state == S_IND_RD);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_TERM_WR;
                    end
                end
                S_TERM_WR: begin
                    if (r_idx == r_n) begin
                        r_state <= S_IND_RD;
                    end else begin
                        r_state <= S_TERM_MUL;
                    end
                end
                S_TERM_MUL: begin
                    if (w_price_done) begin
                        r_state <= S_TERM_WR;
                    end
                end
                S_IND_RD: begin
                    if (r_rd_addr == w_last) begin
                        r_state <= S_IND_DRAIN;
                    end
                end
                S_IND_DRAIN: begin
                    // rows overlap in the RAM, so the pipeline empties first
                    if (!r_rd_vld && !w_ind_busy) begin
                        if (r_m == '0) begin
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_IND_RD;
                        end
                    end
                end
                S_FETCH: r_state <= S_LOAD;
                S_LOAD: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_price  <= i_lowest_price;
                r_strike <= i_strike;
                r_n      <= w_n;
                r_idx    <= '0;
                r_coef   <= '{p: w_p, q: ONE_Q31 - w_p, disc: w_disc};
            end
            S_TERM_WR: begin
                r_m       <= r_n - AW'(1);
                r_rd_addr <= '0;
            end
            S_TERM_MUL: begin
                if (w_price_done) begin
                    r_price <= w_price_res;
                    r_idx   <= r_idx + AW'(1);
                end
            end
            S_IND_RD: begin
                r_rd_addr <= r_rd_addr + AW'(1);
            end
            S_IND_DRAIN: begin
                if (!r_rd_vld && !w_ind_busy) begin
                    r_m       <= r_m - AW'(1);
                    r_rd_addr <= '0;
                end
            end
            S_FETCH: r_idx <= r_idx;
            S_LOAD:  r_result <= w_rdata;
            default: r_idx <= r_idx;
        endcase
        r_rd_tag <= r_rd_addr;
        if (r_rd_vld) begin
            r_prev <= w_rdata;
        end
    end

    // node k arriving pairs with node k-1 held back from the last read
    assign w_req.vld  = r_rd_vld && (r_rd_tag != '0);
    assign w_req.v_lo = r_prev;
    assign w_req.v_hi = w_rdata;
    assign w_req_addr = r_rd_tag - AW'(1);

    assign w_price_start = (r_state == S_TERM_WR) && (r_idx != r_n);

    assign w_we    = (r_state == S_TERM_WR) || w_ind_wr_vld;
    assign w_waddr = w_ind_wr_vld ? w_ind_wr_addr : r_idx;
    assign w_wdata = w_ind_wr_vld ? w_ind_wr_data
                   : ((r_price <= r_strike) ? ONE_Q31 : '0);
    assign w_re    = (r_state == S_IND_RD) || (r_state == S_FETCH);
    assign w_raddr = (r_state == S_FETCH) ? '0 : r_rd_addr;

    btbp_price u_price (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_price_start),
        .i_price (r_price),
        .i_ratio (r_ratio),
        .o_done  (w_price_done),
        .o_price (w_price_res)
    );

    btbp_induct #(
        .AW (AW)
    ) u_induct (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_addr    (w_req_addr),
        .i_coef    (r_coef),
        .o_wr_vld  (w_ind_wr_vld),
        .o_wr_addr (w_ind_wr_addr),
        .o_wr_data (w_ind_wr_data),
        .o_busy    (w_ind_busy)
    );

    btbp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_STEPS + 1)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_done         = r_done;
    assign o_option_value = r_result;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but sequencer stayed idle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ind_wr_vld |-> (r_state == S_IND_RD || r_state == S_IND_DRAIN))
        else $error("induction write outside the induction phase");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_option_value <= ONE_Q31))
        else $error("option value above one");

endmodule

@@ hw/rtl/btbp_ram.sv @@
module btbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/btbp_price.sv @@
module btbp_price (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [btbp_pkg::PRICE_W-1:0]  i_price,
    input  logic [31:0]                   i_ratio,
    output logic                          o_done,
    output logic [btbp_pkg::PRICE_W-1:0]  o_price
);
    import btbp_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0]         r_ph;
    logic [PRICE_W-1:0] r_a;
    logic [31:0]        r_b;
    logic [55:0]        r_plo;
    logic [55:0]        r_phi;
    logic [PRICE_W-1:0] r_res;
    logic               r_done;

    logic [23:0] w_half;
    logic [55:0] w_prod;
    logic [79:0] w_sum;
    logic [49:0] w_shift;

    // one 24x32 multiplier shared by the two halves of the price
    assign w_half  = (r_ph == PH_LO) ? r_a[23:0] : r_a[47:24];
    assign w_prod  = {32'b0, w_half} * {24'b0, r_b};
    assign w_sum   = {r_phi, 24'b0} + {24'b0, r_plo};
    assign w_shift = w_sum[79:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ph <= PH_LO;
                    end
                end
                PH_LO:   r_ph <= PH_HI;
                PH_HI:   r_ph <= PH_SUM;
                PH_SUM: begin
                    r_ph   <= PH_IDLE;
                    r_done <= 1'b1;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_start) begin
            r_a <= i_price;
            r_b <= i_ratio;
        end
        if (r_ph == PH_LO) begin
            r_plo <= w_prod;
        end
        if (r_ph == PH_HI) begin
            r_phi <= w_prod;
        end
        if (r_ph == PH_SUM) begin
            r_res <= (|w_shift[49:48]) ? PRICE_MAX : w_shift[47:0];
        end
    end

    assign o_done  = r_done;
    assign o_price = r_res;

endmodule

@@ hw/rtl/btbp_induct.sv @@
module btbp_induct #(
    parameter int AW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  btbp_pkg::t_ind_req          i_req,
    input  logic [AW-1:0]               i_addr,
    input  btbp_pkg::t_coef             i_coef,
    output logic                        o_wr_vld,
    output logic [AW-1:0]               o_wr_addr,
    output logic [btbp_pkg::VAL_W-1:0]  o_wr_data,
    output logic                        o_busy
);
    import btbp_pkg::*;

    logic             r_v1, r_v2, r_v3;
    logic [AW-1:0]    r_ad1, r_ad2, r_ad3;
    logic [63:0]      r_a, r_b;
    logic [VAL_W-1:0] r_sum;
    logic [63:0]      r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // values stay at or below 1.0, so every term fits in bits [62:31]
    always_ff @(posedge i_clk) begin
        r_a    <= {32'b0, i_req.v_lo} * {32'b0, i_coef.q};
        r_b    <= {32'b0, i_req.v_hi} * {32'b0, i_coef.p};
        r_ad1  <= i_addr;
        r_sum  <= r_a[62:31] + r_b[62:31];
        r_ad2  <= r_ad1;
        r_prod <= {32'b0, r_sum} * {32'b0, i_coef.disc};
        r_ad3  <= r_ad2;
    end

    assign o_wr_vld  = r_v3;
    assign o_wr_addr = r_ad3;
    assign o_wr_data = r_prod[62:31];
    assign o_busy    = r_v1 | r_v2 | r_v3;

endmodule
